// ----- hw/rtl/fifo_translation_buffer_unit_assert.svh -----
// Assertion macros used by the translation buffer back end (ftb_back).
`ifndef FIFO_TRANSLATION_BUFFER_UNIT_ASSERT_SVH
`define FIFO_TRANSLATION_BUFFER_UNIT_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define FTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define FTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ftb_pkg.sv -----
// Types and constants shared by the translation buffer modules.
package ftb_pkg;

  // Buffer geometry
  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);

  // Command queue geometry (depth must be a power of two)
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // Opcodes on the request port
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_INVAL  = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOOKUP,
    CMD_INSERT,
    CMD_INVAL,
    CMD_NOP
  } cmd_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr_in;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] phys_addr_out;
    logic [4:0]  entries_used;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } res_t;

  typedef struct packed {
    cmd_e        op;
    logic [31:0] key;
    logic [31:0] phys;
  } cmd_t;

endpackage

// ----- hw/rtl/ftb_front.sv -----
// Front end: takes request transactions and decodes them into queue commands.
module ftb_front (
  input  logic          start_i,
  input  logic          full_i,
  input  ftb_pkg::req_t req_i,
  output logic          push_o,
  output ftb_pkg::cmd_t cmd_o
);
  import ftb_pkg::*;

  // Accept whenever the command queue has room
  assign push_o = start_i & ~full_i;

  // Classify the opcode; the unused code becomes a no-operation
  always_comb begin
    unique case (req_i.opcode)
      OP_LOOKUP: cmd_o.op = CMD_LOOKUP;
      OP_INSERT: cmd_o.op = CMD_INSERT;
      OP_INVAL:  cmd_o.op = CMD_INVAL;
      default:   cmd_o.op = CMD_NOP;
    endcase
    cmd_o.key  = req_i.virt_addr;
    cmd_o.phys = req_i.phys_addr_in;
  end

endmodule

// ----- hw/rtl/ftb_cmd_fifo.sv -----
// Short command queue between the front end and the buffer back end.
module ftb_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ftb_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ftb_pkg::cmd_t data_o
);
  import ftb_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- hw/rtl/ftb_back.sv -----
// Back end: entry array in insertion order, parallel match, counters, result register.
module ftb_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  ftb_pkg::cmd_t cmd_i,
  output logic          done_o,
  output ftb_pkg::res_t res_o
);
  import ftb_pkg::*;

  `include "fifo_translation_buffer_unit_assert.svh"

  logic [31:0]      key_q [ENTRIES];
  logic [31:0]      key_d [ENTRIES];
  logic [31:0]      val_q [ENTRIES];
  logic [31:0]      val_d [ENTRIES];
  logic [CNT_W-1:0] count_q, count_d;
  logic [31:0]      hit_cnt_q, hit_cnt_d;
  logic [31:0]      miss_cnt_q, miss_cnt_d;
  logic [ENTRIES-1:0] match;
  logic             found;
  logic [IDX_W-1:0] idx;
  logic             full;
  res_t             res_q, res_d;
  logic             done_q;

  assign full = (count_q == CNT_W'(ENTRIES));

  // Compare the key against every occupied slot
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = (CNT_W'(i) < count_q) && (key_q[i] == cmd_i.key);
    end
  end

  // Pick the oldest matching slot
  always_comb begin
    idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        idx = IDX_W'(i);
      end
    end
    found = |match;
  end

  // Carry out the command and build the result
  always_comb begin
    key_d      = key_q;
    val_d      = val_q;
    count_d    = count_q;
    hit_cnt_d  = hit_cnt_q;
    miss_cnt_d = miss_cnt_q;
    res_d      = '0;
    if (cmd_valid_i) begin
      unique case (cmd_i.op)
        CMD_LOOKUP: begin
          if (found) begin
            hit_cnt_d           = hit_cnt_q + 32'd1;
            res_d.hit           = 1'b1;
            res_d.phys_addr_out = val_q[idx];
          end else begin
            miss_cnt_d = miss_cnt_q + 32'd1;
          end
        end
        CMD_INSERT: begin
          if (full) begin
            // Drop the oldest entry and append at the young end
            for (int i = 0; i < ENTRIES - 1; i++) begin
              key_d[i] = key_q[i + 1];
              val_d[i] = val_q[i + 1];
            end
            key_d[ENTRIES-1] = cmd_i.key;
            val_d[ENTRIES-1] = cmd_i.phys;
          end else begin
            for (int i = 0; i < ENTRIES; i++) begin
              if (CNT_W'(i) == count_q) begin
                key_d[i] = cmd_i.key;
                val_d[i] = cmd_i.phys;
              end
            end
            count_d = count_q + 1'b1;
          end
        end
        CMD_INVAL: begin
          if (found) begin
            // Close the gap, keeping the order of younger entries
            for (int i = 0; i < ENTRIES - 1; i++) begin
              if (IDX_W'(i) >= idx) begin
                key_d[i] = key_q[i + 1];
                val_d[i] = val_q[i + 1];
              end
            end
            count_d   = count_q - 1'b1;
            res_d.hit = 1'b1;
          end
        end
        CMD_NOP: begin
        end
      endcase
    end
    res_d.entries_used = 5'(count_d);
    res_d.hit_total    = hit_cnt_d;
    res_d.miss_total   = miss_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
      done_q     <= 1'b0;
    end else begin
      count_q    <= count_d;
      hit_cnt_q  <= hit_cnt_d;
      miss_cnt_q <= miss_cnt_d;
      done_q     <= cmd_valid_i;
    end
  end

  // Hold entry payload and result payload
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  `FTB_ASSERT(a_count_bound, count_q <= CNT_W'(ENTRIES), "occupancy above buffer size")
  `FTB_ASSERT_NEXT(a_one_result, cmd_valid_i, done_q, "command produced no result")
  `FTB_ASSERT_NEXT(a_no_spurious, !cmd_valid_i, !done_q, "result without a command")
  `FTB_ASSERT_NEXT(a_insert_no_hit, cmd_valid_i && cmd_i.op == CMD_INSERT, !res_q.hit, "insert reported a hit")
  `FTB_ASSERT_NEXT(a_lookup_counts, cmd_valid_i && cmd_i.op == CMD_LOOKUP, (hit_cnt_q != $past(hit_cnt_q)) != (miss_cnt_q != $past(miss_cnt_q)), "lookup did not bump exactly one counter")

endmodule

// ----- hw/rtl/fifo_translation_buffer_unit.sv -----
// An accepted request is written into the command queue, popped by the back end and registered in res_q.
// done_o marks each cycle in which res_o holds a new result.
// Throughput: one transaction per cycle; the back end retires one queued command per cycle.
// busy_o stays low: each queued command is retired in the cycle after its push.
// The back end handles each command with a combinational parallel compare and entry shift.
// Reset empties the buffer and clears both counters; entry contents are not cleared.
module fifo_translation_buffer_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  ftb_pkg::req_t req_i,
  output logic          done_o,
  output ftb_pkg::res_t res_o
);
  import ftb_pkg::*;

  logic full;
  logic push;
  cmd_t push_cmd;
  logic q_valid;
  cmd_t q_cmd;

  assign busy_o = full;

  ftb_front u_front (
    .start_i (start_i),
    .full_i  (full),
    .req_i   (req_i),
    .push_o  (push),
    .cmd_o   (push_cmd)
  );

  ftb_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (q_valid),
    .valid_o (q_valid),
    .data_o  (q_cmd)
  );

  ftb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .done_o      (done_o),
    .res_o       (res_o)
  );

endmodule
